### hw/rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, constants and helpers for the epoch-to-calendar converter.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int unsigned SecW    = 32;
    localparam int unsigned OffsetW = 17;
    localparam int unsigned DaysW   = 16;   // 2^32 s / 86400 < 2^16 days

    // divide by constant via reciprocal multiply; divisor code picks the pre-shift
    // and reciprocal: /60 = (x >> 2) / 15, /24 = (x >> 3) / 3, /7 direct
    localparam logic [5:0]      DIVISOR_60     = 6'd60;
    localparam logic [5:0]      DIVISOR_24     = 6'd24;
    localparam logic [5:0]      DIVISOR_7      = 6'd7;
    localparam logic [SecW-1:0] RECIP_15       = 32'h8888_8889;  // ceil(2^35 / 15)
    localparam logic [SecW-1:0] RECIP_3        = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
    localparam logic [SecW-1:0] RECIP_7        = 32'h2492_4925;  // ceil(2^32 / 7)
    localparam logic [DaysW-1:0] EPOCH_WEEKDAY = 16'd4;   // day zero was a Thursday

    localparam logic [7:0] YS_EPOCH = 8'd70;    // 1970
    localparam logic [7:0] YS_1900  = 8'd0;     // century, not leap
    localparam logic [7:0] YS_2100  = 8'd200;   // century, not leap
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_MAY = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_JUL = 4'd6;
    localparam logic [3:0] MONTH_AUG = 4'd7;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_OCT = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    typedef struct packed {
        logic             command;
        logic [SecW-1:0]  epoch_seconds;
    } in_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_STEP      = 4'd2,    // latch quotient from the reciprocal multiply
        OP_SAVE_SEC  = 4'd3,
        OP_SAVE_MIN  = 4'd4,
        OP_SAVE_HOUR = 4'd5,
        OP_SAVE_WDAY = 4'd6,
        OP_YEAR      = 4'd7,
        OP_YEAR_END  = 4'd8,
        OP_MONTH     = 4'd9,
        OP_PUBLISH   = 4'd10
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic year_done;
        logic month_done;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: divider passes, year walk, month walk, result handoff.
// ----------------------------------------------------------------------------
module ets_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  ets_pkg::status_t status,
    output ets_pkg::cmd_t    cmd
);
    import ets_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEC    = 8'b0000_0010,
        ST_MIN    = 8'b0000_0100,
        ST_HOUR   = 8'b0000_1000,
        ST_WDAY   = 8'b0001_0000,
        ST_YEAR   = 8'b0010_0000,
        ST_MONTH  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    op_t    op;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_SEC;
                end
            end
            ST_SEC: begin
                if (!status.div_done) begin
                    op = OP_STEP;
                end else begin
                    op         = OP_SAVE_SEC;
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                if (!status.div_done) begin
                    op = OP_STEP;
                end else begin
                    op         = OP_SAVE_MIN;
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (!status.div_done) begin
                    op = OP_STEP;
                end else begin
                    op         = OP_SAVE_HOUR;
                    state_next = ST_WDAY;
                end
            end
            ST_WDAY: begin
                if (!status.div_done) begin
                    op = OP_STEP;
                end else begin
                    op         = OP_SAVE_WDAY;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (!status.year_done) begin
                    op = OP_YEAR;
                end else begin
                    op         = OP_YEAR_END;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (!status.month_done) begin
                    op = OP_MONTH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the previous result to drain
                if (!m_valid_reg || m_ready) begin
                    op         = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (op == OP_PUBLISH) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign cmd.op  = op;

`ifndef SYNTH
    a_load_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SEC)
        else $error("accepted beat did not start the seconds pass");
    a_publish_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_PUBLISH |-> !m_valid_reg || m_ready)
        else $error("result overwritten before it was taken");
    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("output valid raised outside finish");
`endif

endmodule

### hw/rtl/ets_dp.sv
// ----------------------------------------------------------------------------
// ets_dp
// Datapath: offset add with clamp, reciprocal-multiply divider, year/month walk.
// ----------------------------------------------------------------------------
module ets_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic signed [ets_pkg::OffsetW-1:0] cfg_data,
    input  ets_pkg::in_t                  s_data,
    output ets_pkg::out_t                 m_data,
    input  ets_pkg::cmd_t                 cmd,
    output ets_pkg::status_t              status
);
    import ets_pkg::*;

    logic signed [OffsetW-1:0] offset_reg, offset_next;
    logic [SecW-1:0]  acc_reg, acc_next;       // current dividend
    logic [SecW-1:0]  quo_reg, quo_next;       // quotient of acc_reg
    logic             quo_valid_reg, quo_valid_next;
    logic [5:0]       divisor_reg, divisor_next;
    logic [DaysW-1:0] days_reg, days_next;
    logic [5:0]       sec_reg, sec_next;
    logic [5:0]       min_reg, min_next;
    logic [4:0]       hour_reg, hour_next;
    logic [2:0]       wday_reg, wday_next;
    logic [7:0]       ys_reg, ys_next;
    logic [8:0]       yday_reg, yday_next;
    logic [3:0]       month_reg, month_next;
    out_t             out_reg, out_next;

    logic [SecW+1:0]   sum;
    logic [SecW-1:0]   t_load;
    logic [SecW-1:0]   mul_a;
    logic [SecW-1:0]   mul_k;
    logic [2*SecW-1:0] prod;
    logic [SecW-1:0]   quo_calc;
    logic [11:0]       qd;
    logic [5:0]        rem;
    logic              leap;
    logic [8:0]        ylen;
    logic [4:0]        mlen;
    logic [DaysW-1:0]  wday_dividend;

    // local mode: offset add, clamped to the unsigned 32-bit range; UTC mode passes through
    assign sum = {2'b00, s_data.epoch_seconds}
               + {{(SecW+2-OffsetW){offset_reg[OffsetW-1]}}, offset_reg};
    always_comb begin
        if (!s_data.command) begin
            t_load = s_data.epoch_seconds;
        end else if (sum[SecW+1]) begin
            t_load = '0;
        end else if (sum[SecW]) begin
            t_load = '1;
        end else begin
            t_load = sum[SecW-1:0];
        end
    end

    // quotient: pre-shift, 32x32 multiply by reciprocal, take the high bits
    always_comb begin
        unique case (divisor_reg)
            DIVISOR_60: begin
                mul_a = {2'b00, acc_reg[SecW-1:2]};
                mul_k = RECIP_15;
            end
            DIVISOR_24: begin
                mul_a = {3'b000, acc_reg[SecW-1:3]};
                mul_k = RECIP_3;
            end
            default: begin
                mul_a = acc_reg;
                mul_k = RECIP_7;
            end
        endcase
    end

    // upper halves are zero, so this is a 32x32 product
    assign prod = {{SecW{1'b0}}, mul_a} * {{SecW{1'b0}}, mul_k};

    always_comb begin
        unique case (divisor_reg)
            DIVISOR_60: quo_calc = {3'b000, prod[2*SecW-1:35]};
            DIVISOR_24: quo_calc = {1'b0, prod[2*SecW-1:33]};
            default:    quo_calc = prod[2*SecW-1:SecW];
        endcase
    end

    // remainder is below 64, so six bits of acc - q*d are exact
    assign qd  = {6'b000000, quo_reg[5:0]} * {6'b000000, divisor_reg};
    assign rem = acc_reg[5:0] - qd[5:0];

    // years since 1900: divisible by 4 and not a non-leap century
    assign leap = (ys_reg[1:0] == 2'b00) && (ys_reg != YS_1900) && (ys_reg != YS_2100);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = month_len(month_reg, leap);
    assign wday_dividend = quo_reg[DaysW-1:0] + EPOCH_WEEKDAY;

    assign status.div_done   = quo_valid_reg;
    assign status.year_done  = days_reg < {{(DaysW-9){1'b0}}, ylen};
    assign status.month_done = (month_reg == MONTH_DEC)
                             || (days_reg < {{(DaysW-5){1'b0}}, mlen});

    always_comb begin
        offset_next    = offset_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        quo_valid_next = quo_valid_reg;
        divisor_next   = divisor_reg;
        days_next      = days_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        wday_next      = wday_reg;
        ys_next        = ys_reg;
        yday_next      = yday_reg;
        month_next     = month_reg;
        out_next       = out_reg;

        if (cfg_valid) begin
            offset_next = cfg_data;
        end

        case (cmd.op)
            OP_LOAD: begin
                acc_next       = t_load;
                quo_valid_next = 1'b0;
                divisor_next   = DIVISOR_60;
            end
            OP_STEP: begin
                quo_next       = quo_calc;
                quo_valid_next = 1'b1;
            end
            OP_SAVE_SEC: begin
                sec_next       = rem;
                acc_next       = quo_reg;
                quo_valid_next = 1'b0;
            end
            OP_SAVE_MIN: begin
                min_next       = rem;
                acc_next       = quo_reg;
                quo_valid_next = 1'b0;
                divisor_next   = DIVISOR_24;
            end
            OP_SAVE_HOUR: begin
                hour_next      = rem[4:0];
                days_next      = quo_reg[DaysW-1:0];
                acc_next       = {{(SecW-DaysW){1'b0}}, wday_dividend};
                quo_valid_next = 1'b0;
                divisor_next   = DIVISOR_7;
            end
            OP_SAVE_WDAY: begin
                wday_next      = rem[2:0];
                quo_valid_next = 1'b0;
                ys_next        = YS_EPOCH;
                month_next     = MONTH_JAN;
            end
            OP_YEAR: begin
                days_next = days_reg - {{(DaysW-9){1'b0}}, ylen};
                ys_next   = ys_reg + 8'd1;
            end
            OP_YEAR_END: begin
                yday_next = days_reg[8:0];
            end
            OP_MONTH: begin
                days_next  = days_reg - {{(DaysW-5){1'b0}}, mlen};
                month_next = month_reg + 4'd1;
            end
            OP_PUBLISH: begin
                out_next.second           = sec_reg;
                out_next.minute           = min_reg;
                out_next.hour             = hour_reg;
                out_next.weekday          = wday_reg;
                out_next.years_since_1900 = ys_reg;
                out_next.day_of_year      = yday_reg;
                out_next.month_index      = month_reg;
                out_next.day_of_month     = days_reg[4:0] + 5'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            quo_valid_reg <= 1'b0;
            divisor_reg   <= DIVISOR_60;
            month_reg     <= MONTH_JAN;
        end else begin
            offset_reg    <= offset_next;
            quo_valid_reg <= quo_valid_next;
            divisor_reg   <= divisor_next;
            month_reg     <= month_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        days_reg <= days_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
        wday_reg <= wday_next;
        ys_reg   <= ys_next;
        yday_reg <= yday_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_data    = out_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        quo_valid_reg |-> rem < divisor_reg)
        else $error("divider remainder not reduced");
    a_year_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_YEAR |=> ys_reg == $past(ys_reg) + 8'd1)
        else $error("year walk did not advance");
    a_month_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_MONTH |-> month_reg < MONTH_DEC)
        else $error("month walk past December");
`endif

endmodule

### hw/rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Breaks seconds since 1970-01-01 UTC into Gregorian calendar fields.
// ----------------------------------------------------------------------------
// Sequence: four divides (sec, min, hour, weekday), each a reciprocal multiply
//   then a remainder step; then a year walk over the whole years past 1970
//   (up to 136) and a month walk up to the month index (up to 11).
// Flow: one beat in flight; s_ready returns with m_valid, so a new beat is taken
//   only once the last is through. A result not yet taken holds the sequencer.
// Reset: aresetn synchronous, active low; clears sequencer, m_valid, utc_offset.
module epoch_seconds_to_calendar (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: utc_offset write, always ready
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic signed [ets_pkg::OffsetW-1:0] cfg_data,
    // input beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ets_pkg::in_t                       s_data,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output ets_pkg::out_t                      m_data
);
    import ets_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: divider passes (sec, min, hour, weekday), year walk,
    // month walk, then handoff into the output register
    ets_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: offset register, clamp, reciprocal-multiply divider,
    // leap/month-length logic and the output register
    ets_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for epoch_seconds_to_calendar: drives second counts in
// UTC and local mode across several utc_offset settings, predicts each
// calendar breakdown in the bench and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import ets_pkg::*;

    // command codes carried in the input beat
    localparam logic CMD_UTC   = 1'b0;
    localparam logic CMD_LOCAL = 1'b1;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned FIRST_YEAR   = 1970;
    localparam int unsigned CENTURY_BASE = 1900;
    localparam int unsigned THURSDAY     = 4;
    localparam longint      SEC_TOP      = 64'h0000_0000_FFFF_FFFF;

    // room past the longest conversion, for stray results after the last drain
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_BEATS = 190;      // per offset setting, six settings

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic signed [OffsetW-1:0]   cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    in_t                         s_data;
    logic                        m_valid;
    logic                        m_ready;
    out_t                        m_data;

    epoch_seconds_to_calendar dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // bench-side copy of the offset register and the work still in flight
    logic signed [OffsetW-1:0] offset_shadow;
    in_t                       pending_beats[$];
    out_t                      expected_dates[$];
    logic                      in_beat_taken;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count    = 0;
    int beats_issued;
    int dates_checked  = 0;
    int cfg_writes     = 0;
    int local_beats    = 0;
    int leap_days_seen = 0;
    int errors         = 0;

    // ------------------------------------------------------------------------
    // calendar prediction
    // ------------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned year);
        if (year % 100 == 0)
            return (year % 400) == 0;
        return (year % 4) == 0;
    endfunction

    function automatic int unsigned year_length(input int unsigned year);
        return leap_year(year) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input logic [3:0] mon,
                                                 input int unsigned year);
        case (mon)
            MONTH_FEB: return leap_year(year) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic out_t calendar_of(input in_t beat,
                                         input logic signed [OffsetW-1:0] offs);
        longint      t;
        logic [31:0] secs;
        logic [31:0] days;
        int unsigned year;
        logic [3:0]  mon;
        out_t        date;
        t = longint'(beat.epoch_seconds);
        // local mode: apply offset, clamp to the 32-bit range
        if (beat.command == CMD_LOCAL) begin
            t = t + longint'(offs);
            if (t < 64'sd0)
                t = 64'sd0;
            else if (t > SEC_TOP)
                t = SEC_TOP;
        end
        secs = t[31:0];
        date.second = 6'(secs % 60);
        secs = secs / 60;
        date.minute = 6'(secs % 60);
        secs = secs / 60;
        date.hour = 5'(secs % 24);
        days = secs / 24;
        date.weekday = 3'((days + THURSDAY) % 7);
        year = FIRST_YEAR;
        while (days >= year_length(year)) begin
            days = days - year_length(year);
            year++;
        end
        date.day_of_year = 9'(days);
        mon = MONTH_JAN;
        while (mon < MONTH_DEC && days >= month_length(mon, year)) begin
            days = days - month_length(mon, year);
            mon++;
        end
        date.years_since_1900 = 8'(year - CENTURY_BASE);
        date.month_index      = mon;
        date.day_of_month     = 5'(days + 1);
        return date;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("tb: MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_date(input out_t got, input out_t want);
        if (got.second !== want.second)
            report_mismatch($sformatf("second %0d, want %0d", got.second, want.second));
        if (got.minute !== want.minute)
            report_mismatch($sformatf("minute %0d, want %0d", got.minute, want.minute));
        if (got.hour !== want.hour)
            report_mismatch($sformatf("hour %0d, want %0d", got.hour, want.hour));
        if (got.weekday !== want.weekday)
            report_mismatch($sformatf("weekday %0d, want %0d", got.weekday, want.weekday));
        if (got.years_since_1900 !== want.years_since_1900)
            report_mismatch($sformatf("years_since_1900 %0d, want %0d",
                                      got.years_since_1900, want.years_since_1900));
        if (got.day_of_year !== want.day_of_year)
            report_mismatch($sformatf("day_of_year %0d, want %0d",
                                      got.day_of_year, want.day_of_year));
        if (got.month_index !== want.month_index)
            report_mismatch($sformatf("month_index %0d, want %0d",
                                      got.month_index, want.month_index));
        if (got.day_of_month !== want.day_of_month)
            report_mismatch($sformatf("day_of_month %0d, want %0d",
                                      got.day_of_month, want.day_of_month));
    endtask

    // ------------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge. Config and input
    // beats update the shadow state and the expectation queue; result beats
    // are popped and compared in order.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (!aresetn) begin
            in_beat_taken <= 1'b0;
            offset_shadow = '0;
        end else begin
            in_beat_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                offset_shadow = cfg_data;
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(calendar_of(s_data, offset_shadow));
                if (s_data.command == CMD_LOCAL)
                    local_beats++;
            end
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    out_t want;
                    want = expected_dates.pop_front();
                    compare_date(m_data, want);
                    if (want.month_index == MONTH_FEB && want.day_of_month == 29)
                        leap_days_seen++;
                    dates_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: inputs move at the falling edge. A new beat is offered only once
    // the previous one was taken (or none was up); sender gaps and receiver
    // stalls are drawn per cycle from the current idle percentages.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_beat_taken) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic cmd, input logic [SecW-1:0] secs);
        in_t beat;
        beat.command       = cmd;
        beat.epoch_seconds = secs;
        pending_beats.push_back(beat);
        beats_issued++;
    endtask

    // every beat yields one result, so all results in means the block is idle
    task automatic wait_drained();
        while (dates_checked < beats_issued)
            @(negedge aclk);
    endtask

    task automatic write_offset(input logic signed [OffsetW-1:0] value);
        int target;
        target = cfg_writes + 1;
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (cfg_writes < target);
        cfg_valid <= 1'b0;
    endtask

    // Random second counts: half uniform over the full range, a quarter just
    // around midnight of a random day (year and month rollovers live there),
    // a quarter close to either end of the range where local mode clamps.
    task automatic queue_random_beats(input int count);
        repeat (count) begin
            logic [SecW-1:0] secs;
            case ($urandom_range(0, 3))
                0, 1: secs = $urandom();
                2: secs = $urandom_range(0, 49709) * DAY_SECS + $urandom_range(0, 4) - 2;
                default: begin
                    if ($urandom_range(0, 1))
                        secs = $urandom_range(0, 120000);
                    else
                        secs = 32'hFFFF_FFFF - $urandom_range(0, 120000);
                end
            endcase
            queue_beat($urandom_range(0, 1) ? CMD_LOCAL : CMD_UTC, secs);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence: six offset settings, two per idle profile
    // ------------------------------------------------------------------------
    initial begin
        logic signed [OffsetW-1:0] settings[6];
        int                        rnd_off;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        beats_issued  = 0;

        rnd_off     = $urandom_range(0, 100800);
        settings[0] = '0;                       // reset value, not written
        settings[1] = 17'sd50400;
        settings[2] = -17'sd50400;
        settings[3] = 17'h0FFFF;                // beyond the stated range, both signs
        settings[4] = 17'h10000;
        settings[5] = 17'(rnd_off - 50400);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin send_idle_pct = 17; recv_idle_pct = 80; end
                1: begin send_idle_pct = 80; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p != 0)
                write_offset(settings[p]);

            case (p)
                0: begin
                    // range ends, leap days, century rule, 2^31 boundary
                    queue_beat(CMD_UTC, 32'd0);
                    queue_beat(CMD_UTC, 32'hFFFF_FFFF);
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF);
                    queue_beat(CMD_UTC, 32'd94608000);      // 1972-12-31, day 365
                    queue_beat(CMD_UTC, 32'd946684799);     // 1999-12-31 23:59:59
                    queue_beat(CMD_UTC, 32'd951782400);     // 2000-02-29
                    queue_beat(CMD_UTC, 32'd978220800);     // 2000-12-31, day 365
                    queue_beat(CMD_UTC, 32'd4107542399);    // 2100-02-28 23:59:59
                    queue_beat(CMD_UTC, 32'd4107542400);    // 2100-03-01, no leap day
                    queue_beat(CMD_UTC, 32'd2147483647);
                    queue_beat(CMD_LOCAL, 32'd2147483648);
                end
                1: begin
                    // clamp at the top: exact hit, one past, far past
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF - 32'd50400);
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF - 32'd50399);
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF);
                    queue_beat(CMD_LOCAL, 32'd0);
                end
                2: begin
                    // clamp at the epoch: exact hit, one short, far short
                    queue_beat(CMD_LOCAL, 32'd50400);
                    queue_beat(CMD_LOCAL, 32'd50399);
                    queue_beat(CMD_LOCAL, 32'd0);
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF);
                end
                3, 4: begin
                    queue_beat(CMD_LOCAL, 32'd0);
                    queue_beat(CMD_LOCAL, 32'hFFFF_FFFF);
                end
                default: ;
            endcase

            queue_random_beats(RANDOM_BEATS);
            wait_drained();
        end

        // let anything stray show up before closing out
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

        $display("tb: %0d dates checked, %0d in local mode, over %0d offset writes",
                 dates_checked, local_beats, cfg_writes);
        $display("tb: %0d leap days hit, idle profiles 17/80, 80/17 and none",
                 leap_days_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: a lost beat or a hung handshake ends up here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### epoch_seconds_to_calendar.f
hw/rtl/ets_pkg.sv
hw/rtl/ets_ctrl.sv
hw/rtl/ets_dp.sv
hw/rtl/epoch_seconds_to_calendar.sv
sim/tb.sv
